>>> rtl/bilinear_texture_sampler_wrap_unit_assert.svh
// Assertion macros for the sampler RTL.
// Included by the top level, which checks its own pipeline control.
`ifndef BILINEAR_TEXTURE_SAMPLER_WRAP_UNIT_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_WRAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BTSW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btsw assertion failed");
// next-cycle implication
`define BTSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btsw assertion failed");
`else
`define BTSW_ASSERT_IMP(label, clk, rst, ante, cons)
`define BTSW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/btsw_pkg.sv
// Shared constants, types and helpers for the bilinear wrap sampler.
// No dependencies.
`timescale 1ns / 1ps
package btsw_pkg;
   localparam int MAX_SIDE   = 128;
   localparam int FRAC_W     = 16;
   localparam int CHAN_W     = 8;
   localparam int COORD_W    = 24;
   localparam int SIDE_W     = 8;
   localparam int IDX_W      = $clog2(MAX_SIDE);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int TEXEL_W    = 3 * CHAN_W;
   localparam int PX_W       = COORD_W + SIDE_W;
   localparam int IX_W       = PX_W - FRAC_W;
   localparam int N_W        = IX_W - 1 + SIDE_W;
   localparam int MOD_STEPS  = 4;
   localparam int MOD_STAGES = (N_W + MOD_STEPS - 1) / MOD_STEPS;
   localparam int NP_W       = MOD_STAGES * MOD_STEPS;
   localparam int COORD_LAT  = 2 + MOD_STAGES;
   localparam int WGT_W      = 2 * FRAC_W + 1;
   localparam int ACC_W      = WGT_W + CHAN_W;
   localparam int TAPS       = 4;

   // register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef logic [SIDE_W-1:0]         side_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [FRAC_W-1:0]         frac_type;
   typedef logic signed [COORD_W-1:0] coord_val_type;
   typedef logic [PX_W-1:0]           px_type;
   typedef logic signed [PX_W:0]      pxw_type;
   typedef logic signed [N_W:0]       nw_type;
   typedef logic [N_W-1:0]            n_type;
   typedef logic [NP_W-1:0]           num_type;
   typedef logic [SIDE_W-1:0]         rem_type;
   typedef logic [SIDE_W:0]           step_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [ADDR_W:0]           addr_ext_type;
   typedef logic [FRAC_W:0]           wgt1_type;
   typedef logic [WGT_W-1:0]          wgt_type;
   typedef logic [2*FRAC_W+1:0]       wprod_type;
   typedef logic [ACC_W-1:0]          acc_type;
   typedef logic [CHAN_W-1:0]         chan_type;
   typedef logic [TEXEL_W-1:0]        texel_type;

   // wrapped texel pair and blend fraction of one axis
   typedef struct packed {
      frac_type frac;
      idx_type  lo;
      idx_type  hi;
   } coord_type;

   localparam px_type   HALF   = px_type'(1) << (FRAC_W - 1);
   localparam wgt1_type W_ONE  = wgt1_type'(1) << FRAC_W;
   localparam acc_type  RND    = acc_type'(1) << (2 * FRAC_W - 1);

   // zero means one texel, anything above the store side saturates
   function automatic side_type eff_side(input side_type r);
      side_type s;
      if (r == '0) begin
         s = side_type'(1);
      end else if (r > side_type'(MAX_SIDE)) begin
         s = side_type'(MAX_SIDE);
      end else begin
         s = r;
      end
      return s;
   endfunction
endpackage

>>> rtl/bilinear_texture_sampler_wrap_unit.sv
// Top level of the bilinear repeat-wrap texture sampler.
// Depends on btsw_pkg, btsw_ram, btsw_coord, btsw_blend and the assert header.
//
//  channel | direction | handshake        | payload
//  req     | in        | tvalid / tready  | tuser kind, tdata write or sample fields
//  rsp     | out       | tvalid / tready  | tdata filtered RGB
//  csr     | in        | we               | index, wdata (8-bit side registers)
//
// One request per cycle unless both output queue entries are held. A sample
// passes the input register, the 8-stage per-axis scale and modulo pipeline,
// the address stage, the texel store read, the blend product stage and the queue.
// The store is four replicated 16384-entry RAMs, one read port per tap.
// A two-entry output queue lets the pipeline advance while a result waits;
// it stalls everything only when both entries are held. Reset clears control
// state only; the store is not cleared.
`timescale 1ns / 1ps
`include "bilinear_texture_sampler_wrap_unit_assert.svh"
module bilinear_texture_sampler_wrap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // req_type
   input  logic [87:0] req_tdata,   // texel_index, in_red, in_green, in_blue, u_coord, v_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_red, out_green, out_blue
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   localparam int LAT = btsw_pkg::COORD_LAT;
   localparam int TP  = btsw_pkg::TAPS;

   // side-band fields carried beside the coordinate pipeline
   typedef struct packed {
      logic                sample;
      btsw_pkg::addr_type  index;
      btsw_pkg::texel_type data;
   } side_band_type;

   btsw_pkg::side_type      width_ff, height_ff, w_eff, h_eff;
   logic                    en;
   logic                    s1_vld_ff;
   side_band_type           s1_ff;
   btsw_pkg::coord_val_type u_ff, v_ff;
   logic                    sb_vld_ff [LAT];
   side_band_type           sb_ff     [LAT];
   btsw_pkg::coord_type     cx, cy;
   btsw_pkg::addr_type      addr_in [TP];
   btsw_pkg::wgt_type       wgt_in  [TP];
   btsw_pkg::wgt1_type      wx [2];
   btsw_pkg::wgt1_type      wy [2];
   btsw_pkg::idx_type       xs [2];
   btsw_pkg::idx_type       ys [2];
   logic                    a_vld_ff;
   side_band_type           a_ff;
   btsw_pkg::addr_type      a_addr_ff [TP];
   btsw_pkg::wgt_type       a_wgt_ff  [TP];
   logic                    b_vld_ff;
   btsw_pkg::wgt_type       b_wgt_ff  [TP];
   btsw_pkg::texel_type     texel [TP];
   logic                    ram_we;
   logic                    bl_vld;
   btsw_pkg::texel_type     bl_data;
   logic                    push, pop;
   logic [1:0]              cnt_ff;
   btsw_pkg::texel_type     e0_ff, e1_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= btsw_pkg::side_type'(btsw_pkg::MAX_SIDE);
         height_ff <= btsw_pkg::side_type'(btsw_pkg::MAX_SIDE);
      end else if (csr_we) begin
         unique case (csr_index)
            btsw_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            btsw_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w_eff = btsw_pkg::eff_side(width_ff);
   assign h_eff = btsw_pkg::eff_side(height_ff);

   // pipeline advances unless the output queue is full
   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff.sample <= req_tuser;
         s1_ff.index  <= req_tdata[13:0];
         s1_ff.data   <= req_tdata[37:14];
         u_ff         <= req_tdata[61:38];
         v_ff         <= req_tdata[85:62];
      end
   end

   btsw_coord u_cx (
      .clock(clock), .en(en), .side(w_eff), .coord_in(u_ff), .coord_out(cx)
   );
   btsw_coord u_cy (
      .clock(clock), .en(en), .side(h_eff), .coord_in(v_ff), .coord_out(cy)
   );

   // side-band delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            sb_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         sb_vld_ff[0] <= s1_vld_ff;
         for (int k = 1; k < LAT; k++) begin
            sb_vld_ff[k] <= sb_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= s1_ff;
         for (int k = 1; k < LAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // tap addresses row*width+column and bilinear weights, tap = row*2+column
   always_comb begin
      xs[0] = cx.lo;
      xs[1] = cx.hi;
      ys[0] = cy.lo;
      ys[1] = cy.hi;
      wx[1] = btsw_pkg::wgt1_type'(cx.frac);
      wx[0] = btsw_pkg::W_ONE - wx[1];
      wy[1] = btsw_pkg::wgt1_type'(cy.frac);
      wy[0] = btsw_pkg::W_ONE - wy[1];
      for (int j = 0; j < 2; j++) begin
         for (int i = 0; i < 2; i++) begin
            addr_in[j*2+i] = btsw_pkg::addr_type'(
               btsw_pkg::addr_ext_type'(ys[j]) * btsw_pkg::addr_ext_type'(w_eff)
               + btsw_pkg::addr_ext_type'(xs[i]));
            wgt_in[j*2+i] = btsw_pkg::wgt_type'(
               btsw_pkg::wprod_type'(wx[i]) * btsw_pkg::wprod_type'(wy[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= sb_vld_ff[LAT-1];
         b_vld_ff <= a_vld_ff && a_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= sb_ff[LAT-1];
         a_addr_ff <= addr_in;
         a_wgt_ff  <= wgt_in;
         b_wgt_ff  <= a_wgt_ff;
      end
   end

   // texel store: writes and reads issue from the same stage, in request order
   assign ram_we = en && a_vld_ff && !a_ff.sample;

   genvar g;
   for (g = 0; g < TP; g++) begin : g_bank
      btsw_ram #(
         .WIDTH(btsw_pkg::TEXEL_W),
         .DEPTH(btsw_pkg::MAX_SIDE * btsw_pkg::MAX_SIDE)
      ) u_ram (
         .clock(clock),
         .wr_en(ram_we),
         .wr_addr(a_ff.index),
         .wr_data(a_ff.data),
         .rd_en(en),
         .rd_addr(a_addr_ff[g]),
         .rd_data(texel[g])
      );
   end

   btsw_blend u_blend (
      .clock(clock), .reset(reset), .en(en), .in_vld(b_vld_ff),
      .texel(texel), .wgt(b_wgt_ff), .out_vld(bl_vld), .out_data(bl_data)
   );

   // two-entry output queue
   assign push = en && bl_vld;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      unique case (cnt_ff)
         2'd0: begin
            if (push) begin
               e0_ff <= bl_data;
            end
         end
         2'd1: begin
            if (push && pop) begin
               e0_ff <= bl_data;
            end else if (push) begin
               e1_ff <= bl_data;
            end
         end
         2'd2: begin
            if (pop) begin
               e0_ff <= e1_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = e0_ff;

   `BTSW_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3)
   `BTSW_ASSERT_NEXT(a_full_holds, clock, reset, (cnt_ff == 2'd2) && !rsp_tready, cnt_ff == 2'd2)
   `BTSW_ASSERT_NEXT(a_push_shows, clock, reset, push, rsp_tvalid)
endmodule

>>> rtl/btsw_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module btsw_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/btsw_coord.sv
// One axis: scale by side, add half, split, then repeat-wrap modulo side
// with a pipelined restoring remainder. Depends on btsw_pkg.
`timescale 1ns / 1ps
module btsw_coord (
   input  logic                   clock,
   input  logic                   en,
   input  btsw_pkg::side_type     side,
   input  btsw_pkg::coord_val_type coord_in,
   output btsw_pkg::coord_type    coord_out
);
   localparam int NS = btsw_pkg::MOD_STAGES;

   btsw_pkg::pxw_type  side_s, coord_s, prod;
   btsw_pkg::px_type   px_in, px_ff;
   btsw_pkg::nw_type   ix_s, off_s;
   btsw_pkg::n_type    n_in, n_ff;
   btsw_pkg::frac_type frac0_ff;
   btsw_pkg::rem_type  rem_in [NS];
   btsw_pkg::rem_type  rem_ff [NS];
   btsw_pkg::num_type  num_in [NS];
   btsw_pkg::num_type  num_ff [NS];
   btsw_pkg::frac_type frac_ff [NS];
   btsw_pkg::idx_type  hi, side_m1;

   // p = side * coord + half
   always_comb begin
      side_s  = btsw_pkg::pxw_type'(side);
      coord_s = btsw_pkg::pxw_type'(coord_in);
      prod    = side_s * coord_s;
      px_in   = btsw_pkg::px_type'(prod) + btsw_pkg::HALF;
   end

   // integer part biased by side << (IX_W-1) so the remainder input is non-negative
   always_comb begin
      ix_s  = btsw_pkg::nw_type'($signed(px_ff[btsw_pkg::PX_W-1:btsw_pkg::FRAC_W]));
      off_s = btsw_pkg::nw_type'({side, {(btsw_pkg::IX_W-1){1'b0}}});
      n_in  = btsw_pkg::n_type'(ix_s + off_s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= px_in;
         n_ff     <= n_in;
         frac0_ff <= px_ff[btsw_pkg::FRAC_W-1:0];
      end
   end

   // remainder pipeline, MOD_STEPS bits per stage
   genvar k;
   for (k = 0; k < NS; k++) begin : g_mod
      btsw_pkg::rem_type  r_src;
      btsw_pkg::num_type  n_src;
      btsw_pkg::frac_type f_src;
      btsw_pkg::step_type t;
      if (k == 0) begin : g_first
         assign r_src = '0;
         assign n_src = btsw_pkg::num_type'(n_ff);
         assign f_src = frac0_ff;
      end else begin : g_next
         assign r_src = rem_ff[k-1];
         assign n_src = num_ff[k-1];
         assign f_src = frac_ff[k-1];
      end
      always_comb begin
         rem_in[k] = r_src;
         num_in[k] = n_src;
         t         = '0;
         for (int s = 0; s < btsw_pkg::MOD_STEPS; s++) begin
            t = {rem_in[k], num_in[k][btsw_pkg::NP_W-1]};
            num_in[k] = num_in[k] << 1;
            if (t >= btsw_pkg::step_type'(side)) begin
               t = t - btsw_pkg::step_type'(side);
            end
            rem_in[k] = btsw_pkg::rem_type'(t);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            num_ff[k]  <= num_in[k];
            frac_ff[k] <= f_src;
         end
      end
   end

   // neighbor below wraps to side-1
   always_comb begin
      hi      = btsw_pkg::idx_type'(rem_ff[NS-1]);
      side_m1 = btsw_pkg::idx_type'(side - btsw_pkg::side_type'(1));
      coord_out.frac = frac_ff[NS-1];
      coord_out.hi   = hi;
      coord_out.lo   = (hi == '0) ? side_m1 : hi - btsw_pkg::idx_type'(1);
   end
endmodule

>>> rtl/btsw_blend.sv
// Bilinear blend: per-channel texel times weight, then sum and round.
// Depends on btsw_pkg.
`timescale 1ns / 1ps
module btsw_blend (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  btsw_pkg::texel_type texel [btsw_pkg::TAPS],
   input  btsw_pkg::wgt_type   wgt   [btsw_pkg::TAPS],
   output logic                out_vld,
   output btsw_pkg::texel_type out_data
);
   btsw_pkg::acc_type p_ff [btsw_pkg::TAPS][3];
   btsw_pkg::acc_type acc  [3];
   logic              vld_ff;

   // products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t < btsw_pkg::TAPS; t++) begin
            for (int c = 0; c < 3; c++) begin
               p_ff[t][c] <= btsw_pkg::acc_type'(texel[t][c*btsw_pkg::CHAN_W +:
                             btsw_pkg::CHAN_W]) * btsw_pkg::acc_type'(wgt[t]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   // sum, add half, keep the integer byte
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = p_ff[0][c] + p_ff[1][c] + p_ff[2][c] + p_ff[3][c] + btsw_pkg::RND;
         out_data[c*btsw_pkg::CHAN_W +: btsw_pkg::CHAN_W] =
            acc[c][2*btsw_pkg::FRAC_W +: btsw_pkg::CHAN_W];
      end
   end

   assign out_vld = vld_ff;
endmodule

>>> tb/sv/bilinear_texture_sampler_wrap_unit_tb.sv
// Self-checking testbench for the bilinear repeat-wrap texture sampler.
// Writes texels, samples them and compares each filtered RGB result with the table value or a local blend model.
// Depends on btsw_pkg and bilinear_texture_sampler_wrap_unit.
`timescale 1ns / 1ps
module bilinear_texture_sampler_wrap_unit_tb;
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;
   localparam int   STALL_LIMIT = 4000;
   localparam int   DRAIN_CYCLES = 40;

   typedef struct {
      logic        kind;
      logic [13:0] index;
      logic [7:0]  red, green, blue;
      logic [23:0] u, v;
      logic        has_rgb;     // expected RGB typed in the table
      logic [23:0] rgb;
   } request_row_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [87:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_we, csr_index;
   logic [7:0]  csr_wdata;

   bilinear_texture_sampler_wrap_unit i_dut (.*);

   // local copy of the store and the side registers
   logic [23:0] texels [0:16383];
   bit          written [0:16383];
   int          side_w, side_h;
   logic [23:0] rgb_queue [$];
   int          errors;
   int          idle_count;
   int          send_idle_pct, recv_stall_pct;
   bit          hold_off;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_side(int r);
      return (r == 0) ? 1 : (r > 128 ? 128 : r);
   endfunction

   // bilinear blend with repeat wrap, exact fixed point
   function automatic logic [23:0] blend_rgb(logic [23:0] u, logic [23:0] v);
      longint px, py, ix, iy, fx, fy, acc, wx[2], wy[2];
      int xs[2], ys[2];
      logic [23:0] res;
      px = longint'(side_w) * longint'(signed'(u)) + 32768;
      py = longint'(side_h) * longint'(signed'(v)) + 32768;
      ix = px >>> 16; fx = px & 16'hFFFF;
      iy = py >>> 16; fy = py & 16'hFFFF;
      xs[0] = ((ix - 1) % side_w + side_w) % side_w;
      xs[1] = (ix % side_w + side_w) % side_w;
      ys[0] = ((iy - 1) % side_h + side_h) % side_h;
      ys[1] = (iy % side_h + side_h) % side_h;
      wx[1] = fx; wx[0] = 65536 - fx;
      wy[1] = fy; wy[0] = 65536 - fy;
      for (int c = 0; c < 3; c++) begin
         acc = 0;
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
               acc += longint'(texels[ys[j] * side_w + xs[i]][8*c +: 8]) * wx[i] * wy[j];
         acc += longint'(1) << 31;
         res[8*c +: 8] = 8'(acc >> 32);
      end
      return res;
   endfunction

   // every tap of a sample is already written
   function automatic bit taps_written(logic [23:0] u, logic [23:0] v);
      longint ix, iy;
      int x, y;
      ix = (longint'(side_w) * longint'(signed'(u)) + 32768) >>> 16;
      iy = (longint'(side_h) * longint'(signed'(v)) + 32768) >>> 16;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            x = ((ix - i) % side_w + side_w) % side_w;
            y = ((iy - j) % side_h + side_h) % side_h;
            if (!written[y * side_w + x]) return 0;
         end
      return 1;
   endfunction

   // send one request; predict on acceptance; valid stays up for a following request
   task automatic send_request(request_row_type r);
      logic [23:0] want;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {2'b00, r.v, r.u, r.blue, r.green, r.red, r.index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (r.kind == KIND_WRITE) begin
         texels[r.index]  = {r.blue, r.green, r.red};
         written[r.index] = 1;
      end else begin
         want = blend_rgb(r.u, r.v);
         if (r.has_rgb && want !== r.rgb)
            $display("%0t table row disagrees with blend: %h vs %h", $time, r.rgb, want);
         rgb_queue.push_back(r.has_rgb ? r.rgb : want);
      end
      @(negedge clock);
   endtask

   task automatic write_side(logic idx, int val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= 8'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == btsw_pkg::REG_WIDTH) side_w = clamp_side(val); else side_h = clamp_side(val);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (rgb_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic request_row_type texel_write(int idx, logic [23:0] rgb);
      request_row_type r;
      r = '{KIND_WRITE, 14'(idx), rgb[7:0], rgb[15:8], rgb[23:16], 24'h0, 24'h0, 0, 24'h0};
      r.u = 24'($urandom); r.v = 24'($urandom);   // ignored fields still toggle
      return r;
   endfunction

   function automatic request_row_type sample(logic [23:0] u, logic [23:0] v);
      request_row_type r;
      r = '{KIND_SAMPLE, 14'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            u, v, 0, 24'h0};
      return r;
   endfunction

   // fill the whole active texture, then sample at random with occasional texel writes
   task automatic random_phase(int wv, int hv, int n_samples, int s_idle, int r_stall);
      send_idle_pct = s_idle; recv_stall_pct = r_stall;
      write_side(btsw_pkg::REG_WIDTH, wv);
      write_side(btsw_pkg::REG_HEIGHT, hv);
      for (int i = 0; i < side_w * side_h; i++)
         send_request(texel_write(i, 24'($urandom)));
      for (int i = 0; i < n_samples; i++) begin
         logic [23:0] u, v;
         case ($urandom_range(3))
            0: begin u = 24'($urandom); v = 24'($urandom); end
            1: begin u = 24'($urandom_range(65536)); v = 24'($urandom_range(65536)); end
            2: begin u = 24'(-$urandom_range(200000)); v = 24'($urandom_range(200000)); end
            default: begin u = {$urandom_range(1) ? 8'hFF : 8'h00, 16'($urandom)};
                           v = {$urandom_range(1) ? 8'h7F : 8'h80, 16'($urandom)}; end
         endcase
         if ($urandom_range(9) == 0)
            send_request(texel_write($urandom_range(side_w * side_h - 1), 24'($urandom)));
         else if (taps_written(u, v))
            send_request(sample(u, v));
      end
      drain();
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rgb_queue.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            logic [23:0] want;
            want = rgb_queue.pop_front();
            for (int c = 0; c < 3; c++)
               if (rsp_tdata[8*c +: 8] !== want[8*c +: 8]) begin
                  $display("%0t channel %0d mismatch: expected %h, actual %h",
                           $time, c, want[8*c +: 8], rsp_tdata[8*c +: 8]);
                  errors++;
               end
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

   // watchdog: cycles with no accepted request, result or register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("bilinear_texture_sampler_wrap_unit_tb NOT OK");
         $finish;
      end
   end

   // long receiver hold-off while requests keep coming
   task automatic pressure_phase;
      send_idle_pct = 0; recv_stall_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 40; i++) send_request(sample(24'($urandom), 24'($urandom)));
      join
      drain();
   endtask

   request_row_type table_rows [$];

   initial begin
      errors = 0; idle_count = 0; hold_off = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      side_w = 128; side_h = 128;
      reset = 1; req_tvalid = 0; req_tuser = 0; req_tdata = '0;
      csr_we = 0; csr_index = 0; csr_wdata = '0; rsp_tready = 0;
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: 2x2 texture, extremes and wrap
      write_side(btsw_pkg::REG_WIDTH, 2);
      write_side(btsw_pkg::REG_HEIGHT, 2);
      table_rows.push_back(texel_write(0, 24'hFFFFFF));
      table_rows.push_back(texel_write(1, 24'h000000));
      table_rows.push_back(texel_write(2, 24'hFF00FF));
      table_rows.push_back(texel_write(3, 24'h00FF00));
      table_rows.push_back(texel_write(16383, 24'h123456));
      table_rows.push_back(texel_write(16383, 24'h123456));
      begin
         request_row_type r;
         // texel centers read back the texel itself
         r = sample(24'h004000, 24'h004000); r.has_rgb = 1; r.rgb = 24'hFFFFFF;
         table_rows.push_back(r);
         r = sample(24'h00C000, 24'h00C000); r.has_rgb = 1; r.rgb = 24'h00FF00;
         table_rows.push_back(r);
         r = sample(24'h00C000, 24'h004000); r.has_rgb = 1; r.rgb = 24'h000000;
         table_rows.push_back(r);
      end
      table_rows.push_back(sample(24'h000000, 24'h000000));
      table_rows.push_back(sample(24'h7FFFFF, 24'h800000));
      table_rows.push_back(sample(24'h800000, 24'h7FFFFF));
      table_rows.push_back(sample(24'hFFFFFF, 24'hFFFFFF));
      table_rows.push_back(sample(24'h012345, 24'hFEDCBA));
      table_rows.push_back(sample(24'h555555, 24'hAAAAAA));
      foreach (table_rows[i]) send_request(table_rows[i]);
      drain();

      // zero sides act as one texel, oversize sides saturate; fill the 1x128 column first
      write_side(btsw_pkg::REG_WIDTH, 0);
      write_side(btsw_pkg::REG_HEIGHT, 255);
      for (int i = 0; i < 128; i++)
         send_request(texel_write(i, 24'($urandom)));
      send_request(sample(24'h7FFFFF, 24'h800000));
      send_request(sample(24'h123456, 24'h654321));
      drain();

      random_phase(3, 5, 100, 0, 0);
      random_phase(16, 9, 80, 78, 0);
      random_phase(7, 1, 80, 0, 78);
      random_phase(1, 7, 80, 35, 35);
      random_phase(128, 2, 60, 0, 0);
      pressure_phase();
      random_phase(2, 128, 80, 35, 35);

      if (errors == 0)
         $display("bilinear_texture_sampler_wrap_unit_tb OK");
      else
         $display("bilinear_texture_sampler_wrap_unit_tb NOT OK");
      $finish;
   end
endmodule

>>> bilinear_texture_sampler_wrap_unit.f
+incdir+rtl
rtl/btsw_pkg.sv
rtl/btsw_ram.sv
rtl/btsw_coord.sv
rtl/btsw_blend.sv
rtl/bilinear_texture_sampler_wrap_unit.sv
tb/sv/bilinear_texture_sampler_wrap_unit_tb.sv
